@@ sv/mandelbrot_escape_time_pixel_assert.svh @@
// Assertion macros for the Mandelbrot escape-time pixel engine.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mbe_pkg.sv @@
// Shared types, constants and helpers for the Mandelbrot escape-time engine.
// Depends on nothing; used by every module of the block.
package mbe_pkg;

  // Fixed-point format of z and c.
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned COLOUR_W  = 24;
  localparam int unsigned STEP_W    = 31;

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_W  = VAL_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Width used for sums before saturation.
  localparam int unsigned SAT_W = 48;

  // Colour divider widths.
  localparam int unsigned DIVIDEND_W = ITER_W + COLOUR_W;
  localparam int unsigned DIVISOR_W  = ITER_W;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RE       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IM       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_RE      = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_SCALE  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_COLOUR = 8'd7;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [VAL_W-1:0]  fix_t;
  typedef logic signed [SAT_W-1:0]  wide_t;

  // Saturate a wide signed sum to 32-bit signed.
  function automatic fix_t sat32(wide_t v);
    wide_t max_v;
    wide_t min_v;
    max_v = {{(SAT_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    min_v = {{(SAT_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    if (v > max_v) begin
      return max_v[VAL_W-1:0];
    end else if (v < min_v) begin
      return min_v[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

  // Sign-extend a 32-bit value to the saturation width.
  function automatic wide_t sext_wide(fix_t v);
    return {{(SAT_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

@@ sv/mandelbrot_escape_time_pixel.sv @@
// Top level of the Mandelbrot escape-time pixel engine: config, sequencer, output word.
// Depends on mbe_pkg, mbe_mul, mbe_div and mandelbrot_escape_time_pixel_assert.svh.
//
//   Channel | Signals                                 | Direction
//   cfg     | cfg_valid_i/cfg_ready_o, index, data    | in
//   in      | in_valid_i/in_ready_o, pixel_x, pixel_y | in
//   out     | out_valid_o/out_ready_i, x, y, iter,    | out
//           | inside_res, colour                      |
//
// A pixel takes two mapping products, then its n z updates, all through the one shared multiplier
// (three products per update: zr*zr, zi*zi, zr*zi, then an evaluation step).
// An escaped point with two or more updates adds one multiply and a divider run for colour.
// One pixel is in work at a time; the input is ready only while the sequencer is idle.
// The finished word sits in the output register, so the next pixel is taken while it waits.
// Reset clears the sequencer and loads the default view; config writes are always taken.
module mandelbrot_escape_time_pixel (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mbe_pkg::VAL_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mbe_pkg::COORD_W-1:0]         pixel_x_i,
  input  logic [mbe_pkg::COORD_W-1:0]         pixel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mbe_pkg::COORD_W-1:0]         out_x_o,
  output logic [mbe_pkg::COORD_W-1:0]         out_y_o,
  output logic [mbe_pkg::ITER_W-1:0]          iterations_o,
  output logic                                inside_res_o,
  output logic [mbe_pkg::COLOUR_W-1:0]        colour_o
);
  import mbe_pkg::*;

  `include "mandelbrot_escape_time_pixel_assert.svh"

  // Sequencer states.
  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] ST_MAP_RE  = 4'd1;
  localparam logic [ST_W-1:0] ST_MAP_IM  = 4'd2;
  localparam logic [ST_W-1:0] ST_MAP_END = 4'd3;
  localparam logic [ST_W-1:0] ST_SQ_RR   = 4'd4;
  localparam logic [ST_W-1:0] ST_SQ_II   = 4'd5;
  localparam logic [ST_W-1:0] ST_SQ_RI   = 4'd6;
  localparam logic [ST_W-1:0] ST_EVAL    = 4'd7;
  localparam logic [ST_W-1:0] ST_MUL_CS  = 4'd8;
  localparam logic [ST_W-1:0] ST_DIV_GO  = 4'd9;
  localparam logic [ST_W-1:0] ST_DIV_RUN = 4'd10;
  localparam logic [ST_W-1:0] ST_DONE    = 4'd11;

  // Escape threshold: |z|^2 >= 4 in Q(2*FRAC_BITS) is bit 2*FRAC_BITS+2 or above.
  localparam int unsigned ESC_BIT = 2 * FRAC_BITS + 2;
  localparam int unsigned SUM_W   = PROD_W - 1;

  // Configuration registers.
  fix_t                  origin_re_q, origin_im_q, start_re_q;
  logic [STEP_W-1:0]     step_re_q, step_im_q;
  logic [ITER_W-1:0]     limit_q;
  logic [COLOUR_W-1:0]   scale_q, inside_col_q;

  // Pixel work registers.
  logic [ST_W-1:0]       state_q, state_d;
  logic [COORD_W-1:0]    px_q, px_d, py_q, py_d;
  fix_t                  cr_q, cr_d, ci_q, ci_d;
  fix_t                  zr_q, zr_d, zi_q, zi_d;
  prod_t                 rr_q, rr_d, diff_q, diff_d;
  logic                  esc_q, esc_d;
  logic [ITER_W-1:0]     upd_q, upd_d;
  logic [ITER_W-1:0]     cnt_q, cnt_d;
  logic                  inside_q, inside_d;
  logic [COLOUR_W-1:0]   col_q, col_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [COORD_W-1:0]    ox_q, oy_q;
  logic [ITER_W-1:0]     oit_q;
  logic                  oin_q;
  logic [COLOUR_W-1:0]   ocol_q;
  logic                  out_load;

  // Shared units.
  mul_op_t               mul_a, mul_b;
  prod_t                 prod;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [COLOUR_W-1:0]   div_quot;

  logic [SUM_W-1:0]      sq_sum;
  fix_t                  start_half;
  wide_t                 nr_wide, ni_wide;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q  <= -32'sd563714457;
      origin_im_q  <= -32'sd322122547;
      step_re_q    <= 31'd724775;
      step_im_q    <= 31'd724775;
      start_re_q   <= '0;
      limit_q      <= 16'd50;
      scale_q      <= 24'hFFFFFF;
      inside_col_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_RE:     origin_re_q  <= cfg_data_i;
        REG_ORIGIN_IM:     origin_im_q  <= cfg_data_i;
        REG_STEP_RE:       step_re_q    <= cfg_data_i[STEP_W-1:0];
        REG_STEP_IM:       step_im_q    <= cfg_data_i[STEP_W-1:0];
        REG_START_RE:      start_re_q   <= cfg_data_i;
        REG_ITER_LIMIT:    limit_q      <= cfg_data_i[ITER_W-1:0];
        REG_COLOUR_SCALE:  scale_q      <= cfg_data_i[COLOUR_W-1:0];
        REG_INSIDE_COLOUR: inside_col_q <= cfg_data_i[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  mbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[DIVIDEND_W-1:0]),
    .divisor_i  (limit_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign div_start = (state_q == ST_DIV_GO);

  // Multiplier operand selection by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MAP_RE: begin
        mul_a = {{(MUL_W-COORD_W){1'b0}}, px_q};
        mul_b = {{(MUL_W-STEP_W){1'b0}}, step_re_q};
      end
      ST_MAP_IM: begin
        mul_a = {{(MUL_W-COORD_W){1'b0}}, py_q};
        mul_b = {{(MUL_W-STEP_W){1'b0}}, step_im_q};
      end
      ST_SQ_RR: begin
        mul_a = {zr_q[VAL_W-1], zr_q};
        mul_b = {zr_q[VAL_W-1], zr_q};
      end
      ST_SQ_II: begin
        mul_a = {zi_q[VAL_W-1], zi_q};
        mul_b = {zi_q[VAL_W-1], zi_q};
      end
      ST_SQ_RI: begin
        mul_a = {zr_q[VAL_W-1], zr_q};
        mul_b = {zi_q[VAL_W-1], zi_q};
      end
      ST_MUL_CS: begin
        mul_a = {{(MUL_W-ITER_W){1'b0}}, cnt_q};
        mul_b = {{(MUL_W-COLOUR_W){1'b0}}, scale_q};
      end
      default: ;
    endcase
  end

  // Both squares are non-negative, so their sum fits one bit less than the product.
  assign sq_sum = rr_q[SUM_W-1:0] + prod[SUM_W-1:0];

  // Initial imaginary part is start_re / 2, truncated toward zero.
  assign start_half = $signed(start_re_q + {{(VAL_W-1){1'b0}}, start_re_q[VAL_W-1]}) >>> 1;

  // z update: floor shifts of the products plus c.
  assign nr_wide = SAT_W'(diff_q >>> FRAC_BITS) + sext_wide(cr_q);
  assign ni_wide = SAT_W'(prod >>> (FRAC_BITS - 1)) + sext_wide(ci_q);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    px_d     = px_q;
    py_d     = py_q;
    cr_d     = cr_q;
    ci_d     = ci_q;
    zr_d     = zr_q;
    zi_d     = zi_q;
    rr_d     = rr_q;
    diff_d   = diff_q;
    esc_d    = esc_q;
    upd_d    = upd_q;
    cnt_d    = cnt_q;
    inside_d = inside_q;
    col_d    = col_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          px_d    = pixel_x_i;
          py_d    = pixel_y_i;
          zr_d    = start_re_q;
          zi_d    = start_half;
          upd_d   = '0;
          state_d = ST_MAP_RE;
        end
      end
      ST_MAP_RE: begin
        state_d = ST_MAP_IM;
      end
      ST_MAP_IM: begin
        cr_d    = sat32(SAT_W'(prod) + sext_wide(origin_re_q));
        state_d = ST_MAP_END;
      end
      ST_MAP_END: begin
        ci_d    = sat32(SAT_W'(prod) + sext_wide(origin_im_q));
        state_d = ST_SQ_RR;
      end
      ST_SQ_RR: begin
        state_d = ST_SQ_II;
      end
      ST_SQ_II: begin
        rr_d    = prod;
        state_d = ST_SQ_RI;
      end
      ST_SQ_RI: begin
        diff_d  = rr_q - prod;
        esc_d   = (sq_sum[SUM_W-1:ESC_BIT] != '0);
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (esc_q) begin
          // Escaped: count is updates minus one, clamped at zero.
          inside_d = 1'b0;
          cnt_d    = (upd_q == '0) ? '0 : upd_q - 1'b1;
          col_d    = '0;
          state_d  = (upd_q > ITER_W'(1)) ? ST_MUL_CS : ST_DONE;
        end else if (upd_q >= limit_q) begin
          inside_d = 1'b1;
          cnt_d    = limit_q;
          col_d    = inside_col_q;
          state_d  = ST_DONE;
        end else begin
          zr_d    = sat32(nr_wide);
          zi_d    = sat32(ni_wide);
          upd_d   = upd_q + 1'b1;
          state_d = ST_SQ_RR;
        end
      end
      ST_MUL_CS: begin
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_done) begin
          col_d   = div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the word over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    cr_q     <= cr_d;
    ci_q     <= ci_d;
    zr_q     <= zr_d;
    zi_q     <= zi_d;
    rr_q     <= rr_d;
    diff_q   <= diff_d;
    esc_q    <= esc_d;
    upd_q    <= upd_d;
    cnt_q    <= cnt_d;
    inside_q <= inside_d;
    col_q    <= col_d;
    if (out_load) begin
      ox_q   <= px_q;
      oy_q   <= py_q;
      oit_q  <= cnt_q;
      oin_q  <= inside_q;
      ocol_q <= col_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign iterations_o = oit_q;
  assign inside_res_o = oin_q;
  assign colour_o     = ocol_q;

  // The update counter never runs past the limit.
  `MBE_ASSERT_NOW(a_upd_bound, state_q == ST_EVAL, upd_q <= limit_q, "update count past limit")
  // An escaped word reports fewer iterations than the limit, or none.
  `MBE_ASSERT_NOW(a_esc_count, out_valid_o && !inside_res_o,
                  iterations_o == '0 || iterations_o < limit_q, "escape count out of range")
  // The divider finishes only while the sequencer waits for it.
  `MBE_ASSERT_NOW(a_div_owner, div_done, state_q == ST_DIV_RUN, "stray divider result")
  // The divider works only while the sequencer waits for it.
  `MBE_ASSERT_NOW(a_div_busy, div_busy, state_q == ST_DIV_RUN, "divider busy out of turn")
  // An accepted pixel closes the input until its word is handed over.
  `MBE_ASSERT_NEXT(a_in_closed, in_valid_i && in_ready_o, !in_ready_o, "input reopened early")

endmodule

@@ sv/mbe_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on mbe_pkg for operand and product types.
module mbe_mul (
  input  logic             clk_i,
  input  mbe_pkg::mul_op_t a_i,
  input  mbe_pkg::mul_op_t b_i,
  output mbe_pkg::prod_t   p_o
);
  import mbe_pkg::*;

  prod_t p_q;
  prod_t p_d;

  // One product per cycle, visible the cycle after the operands.
  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ sv/mbe_div.sv @@
// Restoring divider for the colour scaling, one quotient bit per cycle.
// Depends on mbe_pkg for widths.
module mbe_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mbe_pkg::DIVIDEND_W-1:0]      dividend_i,
  input  logic [mbe_pkg::DIVISOR_W-1:0]       divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [mbe_pkg::COLOUR_W-1:0]        quotient_o
);
  import mbe_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] work_q, work_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DIVISOR_W-1:0], work_q[DIVIDEND_W-1]};
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        work_d = {work_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        work_d = {work_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = work_q[COLOUR_W-1:0];

endmodule

@@ bench/mandelbrot_escape_time_pixel_tb.sv @@
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
// Depends on mbe_pkg and mandelbrot_escape_time_pixel; it predicts every result word itself.
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_tb;
  import mbe_pkg::*;

  // Geometry and fixed-point helpers of the bench.
  localparam int unsigned IMAGE_SIZE    = 4096;
  localparam int          ONE_Q         = 1 << FRAC_BITS;
  localparam longint      FIX_MAX       = 64'sd2147483647;
  localparam longint      FIX_MIN       = -64'sd2147483648;
  localparam longint unsigned ESCAPE_MAG = 64'd1 << (2 * FRAC_BITS + 2);
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_GUARD     = 400;
  localparam int unsigned VIEW_ITEMS    = 45;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_LO = 8'd8;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_HI = 8'd255;

  // One result word as the block should deliver it.
  typedef struct {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [ITER_W-1:0]   iters;
    logic                in_set;
    logic [COLOUR_W-1:0] colour;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [ITER_W-1:0]   iterations;
  logic                inside_res;
  logic [COLOUR_W-1:0] colour;

  // Shadow copy of the view registers, loaded with the reset view.
  logic signed [VAL_W-1:0] view_origin_re = -32'sd563714457;
  logic signed [VAL_W-1:0] view_origin_im = -32'sd322122547;
  logic [STEP_W-1:0]       view_step_re   = 31'd724775;
  logic [STEP_W-1:0]       view_step_im   = 31'd724775;
  logic signed [VAL_W-1:0] view_start_re  = '0;
  logic [ITER_W-1:0]       view_limit     = 16'd50;
  logic [COLOUR_W-1:0]     view_scale     = 24'hFFFFFF;
  logic [COLOUR_W-1:0]     view_inside    = '0;

  pixel_word_t pending_pixels[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int          error_count = 0;

  mandelbrot_escape_time_pixel i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .iterations_o (iterations),
    .inside_res_o (inside_res),
    .colour_o     (colour)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Saturate a wide sum to the signed 32-bit range.
  function automatic longint clamp32(input longint v);
    if (v > FIX_MAX) begin
      return FIX_MAX;
    end else if (v < FIX_MIN) begin
      return FIX_MIN;
    end
    return v;
  endfunction

  // Escape-time count and colour of one pixel under the current view.
  function automatic pixel_word_t escape_time_of(input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
    longint c_re, c_im, z_re, z_im, next_re, next_im;
    longint unsigned mag_re, mag_im, mag, count, shade;
    int unsigned updates;
    bit is_inside, done;
    pixel_word_t word;
    c_re = clamp32(longint'(view_origin_re)
                   + (longint'(px) % longint'(IMAGE_SIZE)) * longint'(view_step_re));
    c_im = clamp32(longint'(view_origin_im)
                   + (longint'(py) % longint'(IMAGE_SIZE)) * longint'(view_step_im));
    z_re = longint'(view_start_re);
    z_im = z_re / 2;
    updates = 0;
    is_inside = 1'b0;
    done = 1'b0;
    // The escape test comes before the limit test on every pass.
    while (!done) begin
      mag_re = (z_re < 0) ? -z_re : z_re;
      mag_im = (z_im < 0) ? -z_im : z_im;
      mag = mag_re * mag_re + mag_im * mag_im;
      if (mag >= ESCAPE_MAG) begin
        done = 1'b1;
      end else if (updates >= 32'(view_limit)) begin
        is_inside = 1'b1;
        done = 1'b1;
      end else begin
        next_re = ((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re;
        next_im = ((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im;
        z_re = clamp32(next_re);
        z_im = clamp32(next_im);
        updates++;
      end
    end
    if (is_inside) begin
      count = 64'(view_limit);
      shade = 64'(view_inside);
    end else begin
      count = (updates > 0) ? 64'(updates - 1) : 64'd0;
      shade = (view_limit != 0) ? (count * 64'(view_scale)) / 64'(view_limit) : 64'd0;
    end
    word.x = px;
    word.y = py;
    word.iters = count[ITER_W-1:0];
    word.in_set = is_inside;
    word.colour = shade[COLOUR_W-1:0];
    return word;
  endfunction

  // Random bits above the register width, which the block must drop.
  function automatic logic [VAL_W-1:0] with_noise(input logic [VAL_W-1:0] value,
                                                  input int unsigned width);
    logic [VAL_W-1:0] keep;
    keep = (32'h1 << width) - 1;
    return (value & keep) | ($urandom() & ~keep);
  endfunction

  // Write one configuration word and mirror it in the shadow registers.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_RE:     view_origin_re = data;
      REG_ORIGIN_IM:     view_origin_im = data;
      REG_STEP_RE:       view_step_re   = data[STEP_W-1:0];
      REG_STEP_IM:       view_step_im   = data[STEP_W-1:0];
      REG_START_RE:      view_start_re  = data;
      REG_ITER_LIMIT:    view_limit     = data[ITER_W-1:0];
      REG_COLOUR_SCALE:  view_scale     = data[COLOUR_W-1:0];
      REG_INSIDE_COLOUR: view_inside    = data[COLOUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Load a complete view; narrow registers get junk in their unused bits.
  task automatic program_view(input logic [VAL_W-1:0] origin_re, input logic [VAL_W-1:0] origin_im,
                              input logic [VAL_W-1:0] step_re, input logic [VAL_W-1:0] step_im,
                              input logic [VAL_W-1:0] start_re, input logic [VAL_W-1:0] limit,
                              input logic [VAL_W-1:0] scale, input logic [VAL_W-1:0] inside_col);
    write_reg(REG_ORIGIN_RE, origin_re);
    write_reg(REG_ORIGIN_IM, origin_im);
    write_reg(REG_STEP_RE, with_noise(step_re, STEP_W));
    write_reg(REG_STEP_IM, with_noise(step_im, STEP_W));
    write_reg(REG_START_RE, start_re);
    write_reg(REG_ITER_LIMIT, with_noise(limit, ITER_W));
    write_reg(REG_COLOUR_SCALE, with_noise(scale, COLOUR_W));
    write_reg(REG_INSIDE_COLOUR, with_noise(inside_col, COLOUR_W));
  endtask

  // Send one pixel word, with random idle cycles ahead of it; valid stays up afterwards.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(escape_time_of(x, y));
    @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result word.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    error_count++;
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    pixel_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got x=%0d y=%0d iter=%0d",
                 $time, out_x, out_y, iterations);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", 32'(want.x), 32'(out_x));
        if (out_y !== want.y) report_mismatch("out_y", 32'(want.y), 32'(out_y));
        if (iterations !== want.iters) begin
          report_mismatch("iterations", 32'(want.iters), 32'(iterations));
        end
        if (inside_res !== want.in_set) begin
          report_mismatch("inside_res", 32'(want.in_set), 32'(inside_res));
        end
        if (colour !== want.colour) report_mismatch("colour", 32'(want.colour), 32'(colour));
      end
    end
  end

  // The default view straight out of reset, corners included.
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd1200);
  endtask

  // A start value that has escaped before any update.
  task automatic test_start_escaped();
    wait_idle();
    program_view(32'd0, 32'd0, 32'd0, 32'd0, 2 * ONE_Q, 32'd50, 32'hFFFFFF, 32'h0);
    send_pixel(12'd0, 12'd0);
    wait_idle();
    write_reg(REG_START_RE, 32'h8000_0000);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
    write_reg(REG_START_RE, 32'h7FFF_FFFF);
    send_pixel(12'd17, 12'd33);
    wait_idle();
    // Escaped start with a zero limit: no division, not inside.
    write_reg(REG_ITER_LIMIT, 32'd0);
    send_pixel(12'd5, 12'd6);
    wait_idle();
    // A small negative odd start checks the halving toward zero.
    program_view(-32'sd563714457, -32'sd322122547, 32'd724775, 32'd724775,
                 -32'sd3, 32'd50, 32'hFFFFFF, 32'h0);
    send_pixel(12'd1000, 12'd2000);
  endtask

  // Escape at the very last update allowed, once past 4 and once exactly on it.
  task automatic test_last_update_escape();
    wait_idle();
    program_view(3 * ONE_Q, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFFFF, 32'h00FF00);
    send_pixel(12'd7, 12'd9);
    wait_idle();
    program_view(ONE_Q, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2, 32'hFFFFFF, 32'h00FF00);
    send_pixel(12'd4000, 12'd1);
  endtask

  // A zero limit leaves a bounded start inside.
  task automatic test_zero_limit();
    wait_idle();
    program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0, 32'hFFFFFF);
    send_pixel(12'd123, 12'd456);
  endtask

  // c and z pinned at the ends of the signed range.
  task automatic test_saturation();
    wait_idle();
    program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'sd322122547, 32'd4, 32'h0, 32'hFFFFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
    program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'sd322122547, 32'd4, 32'hFFFFFF, 32'h0);
    send_pixel(12'd4095, 12'd0);
  endtask

  // Writes to indexes that decode to no register must change nothing.
  task automatic test_unused_index();
    wait_idle();
    write_reg(UNUSED_REG_LO, $urandom());
    write_reg(UNUSED_REG_HI, $urandom());
    send_pixel(12'd2222, 12'd3333);
  endtask

  // The largest limit: one point that stays at zero, one just outside the cusp.
  task automatic test_long_limit();
    wait_idle();
    program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF, 32'hFFFFFF, 32'h123456);
    send_pixel(12'd1, 12'd2);
    wait_idle();
    write_reg(REG_ORIGIN_RE, 32'sd69793219);
    send_pixel(12'd3, 12'd4);
  endtask

  // Mostly views over the set itself, sometimes registers full of random bits.
  task automatic program_random_view();
    logic [VAL_W-1:0] start_re;
    logic [VAL_W-1:0] limit;
    if ($urandom_range(0, 4) == 0) begin
      program_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(0, 64), $urandom(), $urandom());
    end else begin
      start_re = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ONE_Q) - ONE_Q / 2 : 0;
      limit = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(1, 64);
      program_view(-(5 * ONE_Q / 2) + $urandom_range(0, 2 * ONE_Q),
                   -(3 * ONE_Q / 2) + $urandom_range(0, ONE_Q),
                   $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17),
                   start_re, limit, $urandom(), $urandom());
    end
  endtask

  // Random pixels over a series of views at the given idle and stall rates.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned i;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (i = 0; i < n_items; i++) begin
      if (i % VIEW_ITEMS == 0) begin
        wait_idle();
        program_random_view();
      end else if ($urandom_range(0, 59) == 0) begin
        // Hold off until the block has emptied, then carry on.
        wait_idle();
      end
      send_pixel(COORD_W'($urandom_range(0, IMAGE_SIZE - 1)),
                 COORD_W'($urandom_range(0, IMAGE_SIZE - 1)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_view();
    test_start_escaped();
    test_last_update_escape();
    test_zero_limit();
    test_saturation();
    test_unused_index();
    test_long_limit();
    test_random_traffic(0, 0, 270);
    test_random_traffic(56, 0, 270);
    test_random_traffic(0, 56, 270);
    test_random_traffic(22, 22, 270);
    wait_idle();
    repeat (END_GUARD) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ mandelbrot_escape_time_pixel.f @@
+incdir+sv
sv/mbe_pkg.sv
sv/mbe_mul.sv
sv/mbe_div.sv
sv/mandelbrot_escape_time_pixel.sv
bench/mandelbrot_escape_time_pixel_tb.sv
